FILE: hdl/text_console_writer_assert.svh
// ----------------------------------------------------------------------------
// text_console_writer_assert.svh
// Assertion macros shared by the console writer RTL. Each macro samples on the
// rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Default screen geometry.
  localparam int DEFAULT_COLUMNS = 80;
  localparam int DEFAULT_ROWS    = 25;

  // Field widths.
  localparam int CHAR_W     = 8;
  localparam int INDEX_W    = 11;
  localparam int CURSOR_W   = 11;
  localparam int CELL_W     = 16;
  localparam int ATTR_W     = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;
  localparam logic [CELL_W-1:0] ZERO_CELL  = 16'h0000;

  // Request kinds.
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Register index of the attribute register.
  localparam logic REG_TEXT_ATTR = 1'b0;

  // Character codes with a meaning of their own.
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_TILDE = 8'd126;

  // What a put request does to the screen store.
  typedef struct packed {
    logic print;   // store the character at the old cursor
    logic clear;   // blank cells 0 through the old cursor
    logic scroll;  // move every row up by one and blank the last row
  } cursor_dec_t;

endpackage

`default_nettype wire

FILE: hdl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = tcw_pkg::CELL_W,
  parameter int DEPTH = tcw_pkg::DEFAULT_COLUMNS * tcw_pkg::DEFAULT_ROWS
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tcw_cursor.sv
// ----------------------------------------------------------------------------
// tcw_cursor
// Row and column cursor with the decode of put characters.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cursor #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEFAULT_ROWS,
  parameter int POS_W   = $clog2(COLUMNS * ROWS)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [tcw_pkg::CHAR_W-1:0]  char_code,
  output logic      [POS_W-1:0]            pos,
  output logic      [POS_W-1:0]            pos_nxt,
  output tcw_pkg::cursor_dec_t             dec
);

  // The column must hold a tab target past the last column.
  localparam int COL_W = $clog2(COLUMNS + 8);
  localparam int ROW_W = $clog2(ROWS + 1);

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_in, row_a;
  logic [COL_W-1:0] col_in, col_a;
  logic             settle;
  logic             wrap;
  logic             home;

  always_comb begin
    row_in = row_r;
    col_in = col_r;
    settle = 1'b0;
    home   = 1'b0;
    dec    = '0;
    case (char_code)
      tcw_pkg::CH_BS: begin
        col_in = (col_r != '0) ? col_r - 1'b1 : col_r;
      end
      tcw_pkg::CH_TAB: begin
        col_in = {col_r[COL_W-1:3] + 1'b1, 3'b000};
        settle = 1'b1;
      end
      tcw_pkg::CH_LF: begin
        row_in = row_r + 1'b1;
        col_in = '0;
        settle = 1'b1;
      end
      tcw_pkg::CH_FF: begin
        home      = 1'b1;
        dec.clear = 1'b1;
      end
      tcw_pkg::CH_CR: begin
        col_in = '0;
      end
      default: begin
        if (char_code >= tcw_pkg::CH_SPACE && char_code <= tcw_pkg::CH_TILDE) begin
          dec.print = 1'b1;
          col_in    = col_r + 1'b1;
          settle    = 1'b1;
        end
      end
    endcase

    // Wrap past the last column, then scroll past the last row.
    wrap       = settle && (col_in >= COL_W'(COLUMNS));
    row_a      = wrap ? row_in + 1'b1 : row_in;
    col_a      = wrap ? '0 : col_in;
    dec.scroll = settle && (row_a >= ROW_W'(ROWS));
    row_nxt    = dec.scroll ? ROW_W'(ROWS - 1) : row_a;
    col_nxt    = col_a;
    if (home) begin
      row_nxt = '0;
      col_nxt = '0;
    end
  end

  assign pos     = POS_W'(row_r * COLUMNS + col_r);
  assign pos_nxt = POS_W'(row_nxt * COLUMNS + col_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (step) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: a screen store of character cells in one RAM, a cursor,
// and a sequencer for reads, scrolling, clearing and the power-up clear.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Contents
// in_       slave      in_tvalid / in_tready     tdata: char_code, cell_index
//                                                tuser: req_type
// out_      master     out_tvalid / out_tready   tdata: cursor_position, read_data
// cfg_      APB slave  psel, penable, pready=1   register 0: text_attribute
//
// A plain put finishes in the accepting cycle and its result follows in the next
// cycle; a read also passes ST_RD for the registered RAM read. A scroll walks
// the RAM one cell per cycle, and a form feed walks cells 0 through the cursor
// position. After reset the RAM is cleared with no transaction accepted. Input
// is taken only in idle with the output register empty or being emptied, so a
// stalled output holds the input too.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::DEFAULT_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEFAULT_ROWS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input stream.
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [7:0] char_code, [18:8] cell_index, [23:19] zero
  input  wire logic [tcw_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] req_type
  input  wire logic                             in_tuser,
  // Result stream.
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [10:0] cursor_position, [26:11] read_data, [31:27] zero
  output logic      [tcw_pkg::OUT_DATA_W-1:0]   out_tdata,
  // Configuration port.
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [tcw_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [tcw_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int POS_W = $clog2(CELLS);
  localparam int EXT_W = (POS_W > tcw_pkg::INDEX_W) ? POS_W : tcw_pkg::INDEX_W;

  localparam logic [POS_W-1:0] LAST     = POS_W'(CELLS - 1);
  localparam logic [POS_W-1:0] COPY_END = POS_W'(CELLS - COLUMNS);
  localparam logic [POS_W-1:0] ROW_OFS  = POS_W'(COLUMNS);

  // Sequencer states.
  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_RD     = 3'd2;
  localparam logic [2:0] ST_SCOPY  = 3'd3;
  localparam logic [2:0] ST_SBLANK = 3'd4;
  localparam logic [2:0] ST_CLEAR  = 3'd5;

  logic [2:0]                       state_r, state_nxt;
  logic [POS_W-1:0]                 cnt_r, cnt_nxt;
  logic [POS_W-1:0]                 clr_end_r, clr_end_nxt;
  logic                             idx_ok_r, idx_ok_nxt;
  logic [tcw_pkg::ATTR_W-1:0]       attr_r, attr_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [tcw_pkg::CURSOR_W-1:0]     out_pos_r, out_pos_nxt;
  logic [tcw_pkg::CELL_W-1:0]       out_data_r, out_data_nxt;

  logic                             in_acc;
  logic                             rd_acc;
  logic                             put_acc;
  logic [tcw_pkg::CHAR_W-1:0]       in_char;
  logic [tcw_pkg::INDEX_W-1:0]      in_idx;
  logic [EXT_W-1:0]                 idx_ext;
  logic [EXT_W-1:0]                 pos_ext;
  logic [EXT_W-1:0]                 cur_ext;

  logic [POS_W-1:0]                 cur_pos;
  logic [POS_W-1:0]                 nxt_pos;
  tcw_pkg::cursor_dec_t             dec;

  logic                             mem_we;
  logic [POS_W-1:0]                 mem_waddr;
  logic [tcw_pkg::CELL_W-1:0]       mem_wdata;
  logic                             mem_re;
  logic [POS_W-1:0]                 mem_raddr;
  logic [tcw_pkg::CELL_W-1:0]       mem_rdata;

  logic                             cfg_wr;

  // --------------------------------------------------------------------------
  // Input decode. Reads and puts share one transaction format.
  // --------------------------------------------------------------------------
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign rd_acc    = in_acc && (in_tuser == tcw_pkg::REQ_READ);
  assign put_acc   = in_acc && (in_tuser == tcw_pkg::REQ_PUT);
  assign in_char   = in_tdata[tcw_pkg::CHAR_W-1:0];
  assign in_idx    = in_tdata[tcw_pkg::CHAR_W +: tcw_pkg::INDEX_W];
  assign idx_ext   = EXT_W'(in_idx);
  assign pos_ext   = EXT_W'(nxt_pos);
  assign cur_ext   = EXT_W'(cur_pos);

  // The cursor moves at the edge that accepts a put; the old position stays
  // available for the store of the character and the form feed range.
  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .POS_W   (POS_W)
  ) u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (put_acc),
    .char_code (in_char),
    .pos       (cur_pos),
    .pos_nxt   (nxt_pos),
    .dec       (dec)
  );

  // --------------------------------------------------------------------------
  // Screen store. Writes always go to lower addresses than the cell being read
  // in the same pass, and every write of a put lands before any later read,
  // so the store needs no forwarding.
  // --------------------------------------------------------------------------
  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = tcw_pkg::BLANK_CELL;
    mem_re    = 1'b0;
    mem_raddr = cnt_r + ROW_OFS;
    case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = tcw_pkg::ZERO_CELL;
      end
      ST_IDLE: begin
        if (rd_acc) begin
          mem_re    = 1'b1;
          mem_raddr = idx_ext[POS_W-1:0];
        end
        if (put_acc && dec.print) begin
          mem_we    = 1'b1;
          mem_waddr = cur_pos;
          mem_wdata = {attr_r, in_char};
        end
      end
      ST_SCOPY: begin
        // Read the cell one row down and write what the previous cycle read
        // into the cell just above it.
        mem_re    = (cnt_r != COPY_END);
        mem_we    = (cnt_r != '0);
        mem_waddr = cnt_r - 1'b1;
        mem_wdata = mem_rdata;
      end
      ST_SBLANK, ST_CLEAR: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer and output register.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    clr_end_nxt   = clr_end_r;
    idx_ok_nxt    = idx_ok_r;
    out_pos_nxt   = out_pos_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_INIT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          out_data_nxt = tcw_pkg::ZERO_CELL;
          cnt_nxt      = '0;
          if (rd_acc) begin
            out_pos_nxt = cur_ext[tcw_pkg::CURSOR_W-1:0];
            idx_ok_nxt  = (32'(in_idx) < CELLS);
            state_nxt   = ST_RD;
          end else begin
            out_pos_nxt = pos_ext[tcw_pkg::CURSOR_W-1:0];
            if (dec.clear) begin
              clr_end_nxt = cur_pos;
              state_nxt   = ST_CLEAR;
            end else if (dec.scroll) begin
              state_nxt = ST_SCOPY;
            end else begin
              out_valid_nxt = 1'b1;
            end
          end
        end
      end
      ST_RD: begin
        out_data_nxt  = idx_ok_r ? mem_rdata : tcw_pkg::ZERO_CELL;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SCOPY: begin
        // The last copy cycle only writes; blanking starts at the same count.
        if (cnt_r == COPY_END) begin
          state_nxt = ST_SBLANK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SBLANK: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == clr_end_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Configuration register. The port is always ready.
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    attr_nxt = attr_r;
    if (cfg_wr && (cfg_paddr[2] == tcw_pkg::REG_TEXT_ATTR)) begin
      attr_nxt = cfg_pwdata[tcw_pkg::ATTR_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == tcw_pkg::REG_TEXT_ATTR)
                    ? {{(tcw_pkg::CFG_DATA_W - tcw_pkg::ATTR_W){1'b0}}, attr_r}
                    : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      attr_r      <= tcw_pkg::ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      attr_r      <= attr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clr_end_r  <= clr_end_nxt;
    idx_ok_r   <= idx_ok_nxt;
    out_pos_r  <= out_pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(tcw_pkg::OUT_DATA_W - tcw_pkg::CELL_W - tcw_pkg::CURSOR_W){1'b0}},
                       out_data_r, out_pos_r};

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

  `TCW_ASSERT_IMP(a_write_in_range, mem_we, 32'(mem_waddr) < CELLS, "RAM write outside the screen")
  `TCW_ASSERT_IMP(a_cursor_in_range, 1'b1, 32'(cur_pos) < CELLS, "cursor outside the screen")
  `TCW_ASSERT_NEXT(a_read_waits, rd_acc, state_r == ST_RD && !out_valid_r, "read not pending")
  `TCW_ASSERT_NEXT(a_scroll_done, state_r == ST_SBLANK && cnt_r == LAST, out_valid_r, "scroll result lost")
  `TCW_ASSERT_IMP(a_init_quiet, state_r == ST_INIT, !out_valid_r && !in_tready, "busy clear not quiet")

endmodule

`default_nettype wire
